// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion wrappers, sampled on clk and idle during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sqcg_pkg.sv -----
// ----------------------------------------------------------------------------
// sqcg_pkg
// Types and constants shared by the sprite quad corner generator.
// ----------------------------------------------------------------------------
package sqcg_pkg;

  localparam logic [1:0] MODE_CENTRED = 2'd0;
  localparam logic [1:0] MODE_TOPLEFT = 2'd1;
  localparam logic [1:0] MODE_ROTATED = 2'd2;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

  // inverse cordic gain and unity, both q30
  localparam logic [31:0] KINV_Q30 = 32'd652032874;
  localparam logic [31:0] ONE_Q30  = 32'd1073741824;

  localparam int MAX_CELLS = 24;

  // arctangent of 2^-i in 2^-32 turns
  localparam logic [31:0] ATAN_TURN32 [0:MAX_CELLS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // one request moving down the cordic row
  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] ax;
    logic [23:0] ay;
    logic [22:0] w;
    logic [22:0] h;
    logic [15:0] u0;
    logic [15:0] v0;
    logic [15:0] du;
    logic [15:0] dv;
    logic [1:0]  quad;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } cell_t;

endpackage

// ----- rtl/sqcg_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// sqcg_cordic_cell
// One rotation step of the cordic row; registers the rotated vector.
// ----------------------------------------------------------------------------
module sqcg_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  sqcg_pkg::cell_t in_data,
  output logic           out_valid,
  output sqcg_pkg::cell_t out_data
);
  import sqcg_pkg::*;

  logic signed [31:0] xs;
  logic signed [31:0] ys;
  cell_t              data_next;

  // arithmetic shift floors toward minus infinity
  assign xs = $signed(in_data.x) >>> IDX;
  assign ys = $signed(in_data.y) >>> IDX;

  always_comb begin
    data_next = in_data;
    if (!in_data.z[31]) begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ATAN_TURN32[IDX];
    end else begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ATAN_TURN32[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/sqcg_corner_unit.sv -----
// ----------------------------------------------------------------------------
// sqcg_corner_unit
// Holds one request and emits its four corners, multiply then round/saturate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sqcg_corner_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sqcg_pkg::cell_t    in_data,
  output logic               in_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic [1:0]         corner_index,
  output logic               last_corner
);
  import sqcg_pkg::*;

  // hold stage
  logic               h_valid;
  logic [1:0]         k;
  logic               h_tl;
  logic [23:0]        h_ax;
  logic [23:0]        h_ay;
  logic [22:0]        h_w;
  logic [22:0]        h_h;
  logic [15:0]        h_u0;
  logic [15:0]        h_v0;
  logic [15:0]        h_du;
  logic [15:0]        h_dv;
  logic signed [31:0] h_c;
  logic signed [31:0] h_s;
  logic [31:0]        c_next;
  logic [31:0]        s_next;

  // product stage
  logic               p_valid;
  logic signed [56:0] p_xc;
  logic signed [56:0] p_ys;
  logic signed [56:0] p_xs;
  logic signed [56:0] p_yc;
  logic [23:0]        p_ax;
  logic [23:0]        p_ay;
  logic [16:0]        p_u;
  logic [16:0]        p_v;
  logic [1:0]         p_k;

  logic               en;
  logic               issue;
  logic               h_free;
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic [58:0]        sum_x;
  logic [58:0]        sum_y;

  localparam logic [58:0] ROUND_HALF = 59'd1 << 30;

  function automatic logic [23:0] sat_pos(input logic [58:0] t);
    logic signed [27:0] q;
    q = t[58:31];
    if (q > 28'sd8388607) begin
      sat_pos = 24'h7FFFFF;
    end else if (q < -28'sd8388608) begin
      sat_pos = 24'h800000;
    end else begin
      sat_pos = q[23:0];
    end
  endfunction

  assign en     = !out_valid || !out_stall;
  assign issue  = h_valid && en;
  assign h_free = !h_valid || (issue && (k == CORNER_BR));
  assign in_take = in_valid && h_free;

  // quadrant fold; unrotated modes use unit cosine
  always_comb begin
    c_next = ONE_Q30;
    s_next = '0;
    if (in_data.mode == MODE_ROTATED) begin
      case (in_data.quad)
        QUAD_I: begin
          c_next = in_data.x;
          s_next = in_data.y;
        end
        QUAD_II: begin
          c_next = -in_data.y;
          s_next = in_data.x;
        end
        QUAD_III: begin
          c_next = -in_data.x;
          s_next = -in_data.y;
        end
        QUAD_IV: begin
          c_next = in_data.y;
          s_next = -in_data.x;
        end
        default: begin
          c_next = ONE_Q30;
          s_next = '0;
        end
      endcase
    end
  end

  // corner offsets in 1/512 units
  always_comb begin
    if (h_tl) begin
      dx = k[0] ? {1'b0, h_w, 1'b0} : '0;
      dy = k[1] ? {1'b0, h_h, 1'b0} : '0;
    end else begin
      dx = k[0] ? {2'b00, h_w} : -{2'b00, h_w};
      dy = k[1] ? {2'b00, h_h} : -{2'b00, h_h};
    end
  end

  always_comb begin
    sum_x = {{4{p_ax[23]}}, p_ax, 31'd0} + {{2{p_xc[56]}}, p_xc}
          - {{2{p_ys[56]}}, p_ys} + ROUND_HALF;
    sum_y = {{4{p_ay[23]}}, p_ay, 31'd0} + {{2{p_xs[56]}}, p_xs}
          + {{2{p_yc[56]}}, p_yc} + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid   <= 1'b0;
      k         <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= k + 2'd1;
        if (k == CORNER_BR) begin
          h_valid <= 1'b0;
        end
      end
      if (in_take) begin
        h_valid <= 1'b1;
        k       <= CORNER_TL;
      end
      if (en) begin
        p_valid   <= h_valid;
        out_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      h_tl <= (in_data.mode == MODE_TOPLEFT);
      h_ax <= in_data.ax;
      h_ay <= in_data.ay;
      h_w  <= in_data.w;
      h_h  <= in_data.h;
      h_u0 <= in_data.u0;
      h_v0 <= in_data.v0;
      h_du <= in_data.du;
      h_dv <= in_data.dv;
      h_c  <= c_next;
      h_s  <= s_next;
    end
    if (en) begin
      p_xc <= dx * h_c;
      p_ys <= dy * h_s;
      p_xs <= dx * h_s;
      p_yc <= dy * h_c;
      p_ax <= h_ax;
      p_ay <= h_ay;
      p_u  <= k[0] ? ({1'b0, h_u0} + {1'b0, h_du}) : {1'b0, h_u0};
      p_v  <= k[1] ? ({1'b0, h_v0} + {1'b0, h_dv}) : {1'b0, h_v0};
      p_k  <= k;
      pos_x        <= sat_pos(sum_x);
      pos_y        <= sat_pos(sum_y);
      tex_u        <= p_u;
      tex_v        <= p_v;
      corner_index <= p_k;
      last_corner  <= (p_k == CORNER_BR);
    end
  end

  `ASSERT_ALWAYS(a_last_flag, !out_valid || (last_corner == (corner_index == CORNER_BR)), "last flag off the fourth corner")
  `ASSERT_NEXT(a_corner_order, out_valid && !out_stall && !last_corner, out_valid && (corner_index == $past(corner_index) + 2'd1), "corner sequence broken")
  `ASSERT_NEXT(a_reload, issue && (k == CORNER_BR), !h_valid || (k == CORNER_TL), "hold stage reloaded mid quad")

endmodule

// ----- rtl/sprite_quad_corner_generator_core.sv -----
// ----------------------------------------------------------------------------
// sprite_quad_corner_generator_core
// Sprite request in, four quad corners out, with cordic rotation in mode 2.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid / in_stall   cmd, anchor_x/y, box_width/height, tex_*,
//                                 turn_angle
//  output   out_valid / out_stall pos_x/y, tex_u/v, corner_index, last_corner
//
//  request rate set by the corner unit, which holds one request and emits
//  one corner per cycle while out_stall is low; the cordic row moves one
//  request per cycle unless stalled; requests pass the cordic cells, then
//  hold/product/output regs; rst clears all valid flags; payload not reset
//  out_stall freezes the corner unit and, once it is full, the cordic row,
//  which then raises in_stall
// ----------------------------------------------------------------------------
module sprite_quad_corner_generator_core #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            cmd,
  input  logic signed [23:0]    anchor_x,
  input  logic signed [23:0]    anchor_y,
  input  logic [22:0]           box_width,
  input  logic [22:0]           box_height,
  input  logic [15:0]           tex_u0,
  input  logic [15:0]           tex_v0,
  input  logic [15:0]           tex_du,
  input  logic [15:0]           tex_dv,
  input  logic [ANGLE_BITS-1:0] turn_angle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [23:0]    pos_x,
  output logic signed [23:0]    pos_y,
  output logic [16:0]           tex_u,
  output logic [16:0]           tex_v,
  output logic [1:0]            corner_index,
  output logic                  last_corner
);
  import sqcg_pkg::*;

  logic        cv [0:CORDIC_STAGES];
  cell_t       cd [0:CORDIC_STAGES];
  cell_t       head;
  logic [31:0] a32;
  logic        take;
  logic        chain_en;

  // angle widened to 2^32 per turn; top two bits pick the quadrant
  assign a32 = {turn_angle, {(32 - ANGLE_BITS){1'b0}}};

  always_comb begin
    head.mode = cmd;
    head.ax   = anchor_x;
    head.ay   = anchor_y;
    head.w    = box_width;
    head.h    = box_height;
    head.u0   = tex_u0;
    head.v0   = tex_v0;
    head.du   = tex_du;
    head.dv   = tex_dv;
    head.quad = a32[31:30];
    head.x    = KINV_Q30;
    head.y    = '0;
    head.z    = {2'b00, a32[29:0]};
  end

  assign cd[0]    = head;
  assign cv[0]    = in_valid;
  assign chain_en = !cv[CORDIC_STAGES] || take;
  assign in_stall = !chain_en;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    sqcg_cordic_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (chain_en),
      .in_valid (cv[i]),
      .in_data  (cd[i]),
      .out_valid(cv[i+1]),
      .out_data (cd[i+1])
    );
  end

  sqcg_corner_unit u_corner (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cv[CORDIC_STAGES]),
    .in_data     (cd[CORDIC_STAGES]),
    .in_take     (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .corner_index(corner_index),
    .last_corner (last_corner)
  );

endmodule

// ----- test/tb_sprite_quad_corner_generator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_quad_corner_generator_core
// Sends sprite requests through the corner generator and checks every corner
// against a local model: exact offsets for the plain modes, a bit-true cordic
// for the rotated mode, round half up and saturation on the positions.
// Directed rows come first, then random requests under several idle patterns.
// ----------------------------------------------------------------------------
module tb_sprite_quad_corner_generator_core;
  import sqcg_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_PRINTS    = 40;
  localparam int DIR_ROWS      = 20;
  localparam int FIXED_ROWS    = 6;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam longint POS_SCALE = 64'sd2147483648;
  localparam longint HALF_LSB  = 64'sd1073741824;
  localparam longint POS_HI    = 64'sd8388607;
  localparam longint POS_LO    = -64'sd8388608;

  typedef struct packed {
    logic [1:0]            cmd;
    logic signed [23:0]    ax;
    logic signed [23:0]    ay;
    logic [22:0]           w;
    logic [22:0]           h;
    logic [15:0]           u0;
    logic [15:0]           v0;
    logic [15:0]           du;
    logic [15:0]           dv;
    logic [ANGLE_BITS-1:0] ang;
    int                    fixed_row;
  } sprite_req_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    corner_t            corner;
    logic               last;
  } corner_exp_t;

  // cmd, anchor x, anchor y, width, height, u0, v0, du, dv, angle
  longint dir_stim [DIR_ROWS][10] = '{
    '{MODE_CENTRED, 0, 0, 512, 256, 0, 0, 0, 0, 0},
    '{MODE_TOPLEFT, 100, -50, 512, 256, 4096, 8192, 16384, 32768, 0},
    '{MODE_CENTRED, 8388607, -8388608, 8388607, 8388607, 65535, 65535, 65535, 65535, 0},
    '{MODE_TOPLEFT, -8388608, 8388607, 8388607, 8388607, 0, 0, 0, 0, 65535},
    '{MODE_SPARE, 0, 0, 3, 1, 1, 2, 3, 4, 16384},
    '{MODE_ROTATED, -3, 9, 0, 0, 65535, 0, 1, 65535, 4660},
    '{MODE_ROTATED, 0, 0, 2560, 1280, 0, 0, 65535, 65535, 0},
    '{MODE_ROTATED, 0, 0, 2560, 1280, 100, 200, 300, 400, 16384},
    '{MODE_ROTATED, 0, 0, 2560, 1280, 0, 0, 0, 0, 32768},
    '{MODE_ROTATED, 0, 0, 2560, 1280, 0, 0, 0, 0, 49152},
    '{MODE_ROTATED, 512, -512, 2560, 1280, 0, 0, 0, 0, 65535},
    '{MODE_ROTATED, 0, 0, 65536, 65536, 0, 0, 0, 0, 8192},
    '{MODE_ROTATED, 0, 0, 65536, 32768, 0, 0, 0, 0, 1},
    '{MODE_ROTATED, 8388607, 8388607, 8388607, 8388607, 0, 0, 0, 0, 8192},
    '{MODE_ROTATED, -8388608, -8388608, 8388607, 8388607, 0, 0, 0, 0, 40960},
    '{MODE_ROTATED, 1000, -1000, 1, 1, 0, 0, 0, 0, 24576},
    '{MODE_CENTRED, -1, -1, 1, 8388607, 32768, 32768, 32768, 32768, 0},
    '{MODE_TOPLEFT, 0, 0, 0, 0, 65535, 65535, 65535, 65535, 0},
    '{MODE_SPARE, 12345, -6789, 777, 333, 11, 22, 33, 44, 65535},
    '{MODE_ROTATED, 256, 256, 4194304, 2, 0, 65535, 65535, 0, 12288}
  };

  // hand-computed positions for the first rows: x/y of tl, tr, bl, br
  longint dir_pos [FIXED_ROWS][8] = '{
    '{-256, -128, 256, -128, -256, 128, 256, 128},
    '{100, -50, 612, -50, 100, 206, 612, 206},
    '{4194304, -8388608, 8388607, -8388608, 4194304, -4194304, 8388607, -4194304},
    '{-8388608, 8388607, -1, 8388607, -8388608, 8388607, -1, 8388607},
    '{-1, 0, 2, 0, -1, 1, 2, 1},
    '{-3, 9, -3, 9, -3, 9, -3, 9}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            cmd = '0;
  logic signed [23:0]    anchor_x = '0;
  logic signed [23:0]    anchor_y = '0;
  logic [22:0]           box_width = '0;
  logic [22:0]           box_height = '0;
  logic [15:0]           tex_u0 = '0;
  logic [15:0]           tex_v0 = '0;
  logic [15:0]           tex_du = '0;
  logic [15:0]           tex_dv = '0;
  logic [ANGLE_BITS-1:0] turn_angle = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [23:0]    pos_x;
  logic signed [23:0]    pos_y;
  logic [16:0]           tex_u;
  logic [16:0]           tex_v;
  logic [1:0]            corner_index;
  logic                  last_corner;

  sprite_req_t sprite_q [$];
  corner_exp_t corner_q [$];
  sprite_req_t cur_req;
  corner_exp_t got_exp;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int sent_count = 0;
  int corners_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int phases = 0;

  sprite_quad_corner_generator_core #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .anchor_x    (anchor_x),
    .anchor_y    (anchor_y),
    .box_width   (box_width),
    .box_height  (box_height),
    .tex_u0      (tex_u0),
    .tex_v0      (tex_v0),
    .tex_du      (tex_du),
    .tex_dv      (tex_dv),
    .turn_angle  (turn_angle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .corner_index(corner_index),
    .last_corner (last_corner)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sine and cosine in q30, quadrant folded after the rotation
  function automatic void cordic_sincos(input logic [ANGLE_BITS-1:0] ang,
                                        output longint cos_v, output longint sin_v);
    logic [31:0] a32;
    longint x, y, z, xs, ys;
    a32 = 32'(ang) << (32 - ANGLE_BITS);
    z = longint'(a32[29:0]);
    x = longint'(KINV_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < MAX_CELLS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURN32[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURN32[i]);
      end
    end
    case (a32[31:30])
      QUAD_I: begin
        cos_v = x;
        sin_v = y;
      end
      QUAD_II: begin
        cos_v = -y;
        sin_v = x;
      end
      QUAD_III: begin
        cos_v = -x;
        sin_v = -y;
      end
      default: begin
        cos_v = y;
        sin_v = -x;
      end
    endcase
  endfunction

  // 2^-39 units down to 8 fraction bits, round half up, then clamp
  function automatic logic signed [23:0] round_sat(input longint v);
    longint p;
    p = (v + HALF_LSB) >>> 31;
    if (p > POS_HI) p = POS_HI;
    if (p < POS_LO) p = POS_LO;
    return 24'(p);
  endfunction

  // queues the four corners a request must produce
  function automatic void quad_corners(input sprite_req_t r);
    longint cos_q30, sin_q30, base_x, base_y, wd, ht, dx, dy;
    logic right, bottom;
    corner_exp_t e;
    cos_q30 = longint'(ONE_Q30);
    sin_q30 = 0;
    if (r.cmd == MODE_ROTATED) cordic_sincos(r.ang, cos_q30, sin_q30);
    base_x = longint'(r.ax) * POS_SCALE;
    base_y = longint'(r.ay) * POS_SCALE;
    wd = longint'(r.w);
    ht = longint'(r.h);
    for (int k = 0; k < 4; k++) begin
      right = k[0];
      bottom = k[1];
      // offsets in 1/512 units so half sizes stay exact
      if (r.cmd == MODE_TOPLEFT) begin
        dx = right ? 2 * wd : 0;
        dy = bottom ? 2 * ht : 0;
      end else begin
        dx = right ? wd : -wd;
        dy = bottom ? ht : -ht;
      end
      e.pos_x = round_sat(base_x + dx * cos_q30 - dy * sin_q30);
      e.pos_y = round_sat(base_y + dx * sin_q30 + dy * cos_q30);
      if (r.fixed_row >= 0) begin
        e.pos_x = 24'(dir_pos[r.fixed_row][2 * k]);
        e.pos_y = 24'(dir_pos[r.fixed_row][2 * k + 1]);
      end
      e.tex_u = right ? 17'(r.u0) + 17'(r.du) : 17'(r.u0);
      e.tex_v = bottom ? 17'(r.v0) + 17'(r.dv) : 17'(r.v0);
      e.corner = corner_t'(k[1:0]);
      e.last = (k == 3);
      corner_q.push_back(e);
    end
  endfunction

  function automatic sprite_req_t rand_sprite();
    sprite_req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) r.cmd = MODE_ROTATED;
    else if (pick < 65) r.cmd = MODE_CENTRED;
    else if (pick < 90) r.cmd = MODE_TOPLEFT;
    else r.cmd = MODE_SPARE;
    // mostly small boxes near the origin, some across the whole range
    r.ax = ($urandom_range(3) == 0) ? 24'($urandom()) : 24'(int'($urandom_range(16383)) - 8192);
    r.ay = ($urandom_range(3) == 0) ? 24'($urandom()) : 24'(int'($urandom_range(16383)) - 8192);
    r.w = ($urandom_range(4) == 0) ? 23'($urandom()) : 23'($urandom_range(8191));
    r.h = ($urandom_range(4) == 0) ? 23'($urandom()) : 23'($urandom_range(8191));
    r.u0 = 16'($urandom());
    r.v0 = 16'($urandom());
    r.du = 16'($urandom());
    r.dv = 16'($urandom());
    r.ang = ANGLE_BITS'($urandom());
    r.fixed_row = -1;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] corner %0d: %s is %0d, model says %0d", $time, corners_seen, what,
               got, want);
    mismatches++;
  endtask

  task automatic drain_all();
    while (sprite_q.size() != 0 || in_valid) @(negedge clk);
    while (corner_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input int n, input int send_pct, input int recv_pct,
                            input bit long_hold);
    int start;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = sent_count;
    for (int i = 0; i < n; i++) sprite_q.push_back(rand_sprite());
    if (long_hold) begin
      // receiver holds off while requests keep coming, so the row backs up
      while (sent_count < start + 5) @(negedge clk);
      hold_left = 150;
    end
    drain_all();
    phases++;
  endtask

  // request side
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        quad_corners(cur_req);
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (sprite_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = sprite_q.pop_front();
          in_valid <= 1'b1;
          cmd <= cur_req.cmd;
          anchor_x <= cur_req.ax;
          anchor_y <= cur_req.ay;
          box_width <= cur_req.w;
          box_height <= cur_req.h;
          tex_u0 <= cur_req.u0;
          tex_v0 <= cur_req.v0;
          tex_du <= cur_req.du;
          tex_dv <= cur_req.dv;
          turn_angle <= cur_req.ang;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // corner side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (corner_q.size() == 0) begin
          flag_mismatch("corner with no request pending, index", corner_index, 0);
        end else begin
          got_exp = corner_q.pop_front();
          if (pos_x !== got_exp.pos_x) flag_mismatch("pos_x", pos_x, got_exp.pos_x);
          if (pos_y !== got_exp.pos_y) flag_mismatch("pos_y", pos_y, got_exp.pos_y);
          if (tex_u !== got_exp.tex_u) flag_mismatch("tex_u", tex_u, got_exp.tex_u);
          if (tex_v !== got_exp.tex_v) flag_mismatch("tex_v", tex_v, got_exp.tex_v);
          if (corner_index !== got_exp.corner)
            flag_mismatch("corner_index", corner_index, got_exp.corner);
          if (last_corner !== got_exp.last)
            flag_mismatch("last_corner", last_corner, got_exp.last);
        end
        corners_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d corners still pending", cycles, corner_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sprite_req_t r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      r.cmd = 2'(dir_stim[i][0]);
      r.ax = 24'(dir_stim[i][1]);
      r.ay = 24'(dir_stim[i][2]);
      r.w = 23'(dir_stim[i][3]);
      r.h = 23'(dir_stim[i][4]);
      r.u0 = 16'(dir_stim[i][5]);
      r.v0 = 16'(dir_stim[i][6]);
      r.du = 16'(dir_stim[i][7]);
      r.dv = 16'(dir_stim[i][8]);
      r.ang = ANGLE_BITS'(dir_stim[i][9]);
      r.fixed_row = (i < FIXED_ROWS) ? i : -1;
      sprite_q.push_back(r);
    end
    drain_all();
    phases++;

    // each phase ends with the sender paused until all corners are back
    run_random(60, 0, 0, 1'b0);
    run_random(50, 78, 0, 1'b0);
    run_random(50, 0, 78, 1'b0);
    run_random(50, 14, 14, 1'b1);

    repeat (CORDIC_STAGES + 12) @(negedge clk);
    $display("%0d sprite requests (%0d directed) over %0d phases, %0d corners checked",
             sent_count, DIR_ROWS, phases, corners_seen);
    $display("modes centred, top-left, rotated and spare; %0d mismatches", mismatches);
    if (mismatches == 0 && corner_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sqcg_pkg.sv
rtl/sqcg_cordic_cell.sv
rtl/sqcg_corner_unit.sv
rtl/sprite_quad_corner_generator_core.sv
test/tb_sprite_quad_corner_generator_core.sv
